### hdl/hs_pkg.sv
// Shared constants, types and controller/datapath handshake structs for the heap sorter.
`default_nettype none
package hs_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KID_W = CNT_W + 1;
    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [KID_W-1:0] kid_t;

    // Controller to datapath commands
    typedef struct packed {
        logic in_open;
        logic set_k;
        logic set_end;
        logic dec_idx;
        logic sift_begin;
        logic take_val;
        logic read_kids;
        logic sift_step;
        logic ex_read;
        logic ex_swap;
        logic em_clear;
        logic em_read;
        logic em_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_fire;
        logic idx_zero;
        logic sift_done;
        logic out_free;
        logic em_last;
    } stat_t;

endpackage
`default_nettype wire

### hdl/hs_if.sv
// Valid/ready channel interfaces for input items and sorted results.
`default_nettype none
interface hs_in_if;
    logic valid;
    logic ready;
    hs_pkg::word_t value;
    logic last;

    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

interface hs_out_if;
    logic valid;
    logic ready;
    hs_pkg::word_t sorted_value;
    logic end_of_set;
    logic overflow;

    modport source (output valid, output sorted_value, output end_of_set, output overflow,
                    input ready);
    modport sink (input valid, input sorted_value, input end_of_set, input overflow,
                  output ready);
endinterface
`default_nettype wire

### hdl/hs_dp.sv
// Heap sort datapath: element memory, sift registers, counters and output register.
`default_nettype none
module hs_dp (
    input  wire logic        clk,
    input  wire logic        rst_n,
    hs_in_if.sink            items,
    hs_out_if.source         results,
    input  hs_pkg::cmd_t     cmd,
    output hs_pkg::stat_t    stat
);

    // element memory, one write and two read ports, registered reads
    hs_pkg::word_t mem [hs_pkg::DEPTH];
    hs_pkg::word_t rd_a_reg;
    hs_pkg::word_t rd_b_reg;

    hs_pkg::cnt_t  cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    hs_pkg::cnt_t  n_reg;
    logic          set_ovf_reg;
    hs_pkg::cnt_t  idx_reg;
    hs_pkg::cnt_t  hs_reg;
    hs_pkg::cnt_t  em_reg;
    hs_pkg::idx_t  cur_reg;
    hs_pkg::word_t val_reg;

    logic          out_valid_reg, out_valid_next;
    hs_pkg::word_t out_value_reg;
    logic          out_end_reg;
    logic          out_ovf_reg;

    logic          in_fire;
    logic          room;
    hs_pkg::kid_t  left_idx, right_idx;
    logic          left_ok, right_ok;
    logic          pick_right;
    hs_pkg::word_t child_val;
    hs_pkg::kid_t  child_idx;
    logic          move;

    logic          we;
    hs_pkg::idx_t  waddr;
    hs_pkg::word_t wdata;
    logic          re_a, re_b;
    hs_pkg::idx_t  raddr_a, raddr_b;

    assign items.ready = cmd.in_open;
    assign in_fire     = items.valid && items.ready;
    assign room        = cnt_reg < hs_pkg::CNT_W'(hs_pkg::DEPTH);

    // children of the current slot
    assign left_idx   = {1'b0, cur_reg, 1'b1};
    assign right_idx  = {1'b0, cur_reg, 1'b1} + hs_pkg::KID_W'(1);
    assign left_ok    = left_idx < {1'b0, hs_reg};
    assign right_ok   = right_idx < {1'b0, hs_reg};
    assign pick_right = right_ok && (rd_b_reg > rd_a_reg);
    assign child_val  = pick_right ? rd_b_reg : rd_a_reg;
    assign child_idx  = pick_right ? right_idx : left_idx;
    assign move       = left_ok && (child_val > val_reg);

    // memory port selection
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = items.value;
        if (in_fire && room)
        begin
            we    = 1'b1;
            waddr = cnt_reg[hs_pkg::IDX_W-1:0];
            wdata = items.value;
        end
        else if (cmd.sift_step)
        begin
            we    = 1'b1;
            waddr = cur_reg;
            wdata = move ? child_val : val_reg;
        end
        else if (cmd.ex_swap)
        begin
            we    = 1'b1;
            waddr = idx_reg[hs_pkg::IDX_W-1:0];
            wdata = rd_a_reg;
        end
    end

    always_comb
    begin
        re_a    = 1'b0;
        re_b    = 1'b0;
        raddr_a = '0;
        raddr_b = '0;
        if (cmd.sift_begin)
        begin
            re_a    = 1'b1;
            raddr_a = hs_pkg::IDX_W'(idx_reg - hs_pkg::CNT_W'(1));
        end
        else if (cmd.read_kids)
        begin
            re_a    = 1'b1;
            re_b    = 1'b1;
            raddr_a = left_idx[hs_pkg::IDX_W-1:0];
            raddr_b = right_idx[hs_pkg::IDX_W-1:0];
        end
        else if (cmd.ex_read)
        begin
            re_a    = 1'b1;
            re_b    = 1'b1;
            raddr_a = '0;
            raddr_b = idx_reg[hs_pkg::IDX_W-1:0];
        end
        else if (cmd.em_read)
        begin
            re_a    = 1'b1;
            raddr_a = em_reg[hs_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rd_a_reg <= mem[raddr_a];
        end
        if (re_b)
        begin
            rd_b_reg <= mem[raddr_b];
        end
    end

    // set bookkeeping
    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (in_fire)
        begin
            if (items.last)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + hs_pkg::CNT_W'(room);
                ovf_next = ovf_reg || !room;
            end
        end
    end

    // slot is handed out only when free, so a load never meets a full register
    assign out_valid_next = cmd.em_load || (out_valid_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && items.last)
        begin
            n_reg       <= cnt_reg + hs_pkg::CNT_W'(room);
            set_ovf_reg <= ovf_reg || !room;
        end
        if (cmd.set_k)
        begin
            idx_reg <= n_reg >> 1;
        end
        else if (cmd.set_end)
        begin
            idx_reg <= n_reg - hs_pkg::CNT_W'(1);
        end
        else if (cmd.dec_idx)
        begin
            idx_reg <= idx_reg - hs_pkg::CNT_W'(1);
        end
        if (cmd.sift_begin)
        begin
            cur_reg <= hs_pkg::IDX_W'(idx_reg - hs_pkg::CNT_W'(1));
            hs_reg  <= n_reg;
        end
        else if (cmd.sift_step && move)
        begin
            cur_reg <= child_idx[hs_pkg::IDX_W-1:0];
        end
        else if (cmd.ex_swap)
        begin
            cur_reg <= '0;
            hs_reg  <= idx_reg;
        end
        if (cmd.take_val)
        begin
            val_reg <= rd_a_reg;
        end
        else if (cmd.ex_swap)
        begin
            val_reg <= rd_b_reg;
        end
        if (cmd.em_clear)
        begin
            em_reg <= '0;
        end
        else if (cmd.em_load)
        begin
            em_reg <= em_reg + hs_pkg::CNT_W'(1);
        end
        if (cmd.em_load)
        begin
            out_value_reg <= rd_a_reg;
            out_end_reg   <= stat.em_last;
            out_ovf_reg   <= set_ovf_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.sorted_value = out_value_reg;
    assign results.end_of_set   = out_end_reg;
    assign results.overflow     = out_ovf_reg;

    assign stat.last_fire = in_fire && items.last;
    assign stat.idx_zero  = idx_reg == '0;
    assign stat.sift_done = !move;
    assign stat.out_free  = !out_valid_reg || results.ready;
    assign stat.em_last   = em_reg == (n_reg - hs_pkg::CNT_W'(1));

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= hs_pkg::CNT_W'(hs_pkg::DEPTH))
        else $error("element count beyond store depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.em_load |-> !out_valid_reg)
        else $error("result loaded over a pending transaction");

    a_move_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sift_step && move) |-> (child_idx < {1'b0, hs_reg}))
        else $error("sift moved outside the heap");

    a_no_load_during_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sift_step || cmd.ex_swap) |-> !in_fire)
        else $error("input accepted while sorting");

endmodule
`default_nettype wire

### hdl/hs_ctrl.sv
// Heap sort controller: sequences load, heap build, extraction and result emission.
`default_nettype none
module hs_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  hs_pkg::stat_t    stat,
    output hs_pkg::cmd_t     cmd
);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_KINIT  = 4'd1;
    localparam logic [3:0] S_BUILD  = 4'd2;
    localparam logic [3:0] S_SFIRST = 4'd3;
    localparam logic [3:0] S_SCMP   = 4'd4;
    localparam logic [3:0] S_SRD    = 4'd5;
    localparam logic [3:0] S_EXINIT = 4'd6;
    localparam logic [3:0] S_EXTR   = 4'd7;
    localparam logic [3:0] S_EXSWAP = 4'd8;
    localparam logic [3:0] S_EMRD   = 4'd9;
    localparam logic [3:0] S_EMLD   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       extract_reg, extract_next;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        extract_next = extract_reg;
        case (state_reg)
            S_LOAD:
            begin
                cmd.in_open = 1'b1;
                if (stat.last_fire)
                begin
                    state_next = S_KINIT;
                end
            end
            S_KINIT:
            begin
                cmd.set_k  = 1'b1;
                state_next = S_BUILD;
            end
            S_BUILD:
            begin
                if (stat.idx_zero)
                begin
                    state_next = S_EXINIT;
                end
                else
                begin
                    cmd.sift_begin = 1'b1;
                    extract_next   = 1'b0;
                    state_next     = S_SFIRST;
                end
            end
            S_SFIRST:
            begin
                cmd.take_val  = 1'b1;
                cmd.read_kids = 1'b1;
                state_next    = S_SCMP;
            end
            S_SCMP:
            begin
                cmd.sift_step = 1'b1;
                if (stat.sift_done)
                begin
                    cmd.dec_idx = 1'b1;
                    state_next  = extract_reg ? S_EXTR : S_BUILD;
                end
                else
                begin
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                cmd.read_kids = 1'b1;
                state_next    = S_SCMP;
            end
            S_EXINIT:
            begin
                cmd.set_end = 1'b1;
                state_next  = S_EXTR;
            end
            S_EXTR:
            begin
                if (stat.idx_zero)
                begin
                    cmd.em_clear = 1'b1;
                    state_next   = S_EMRD;
                end
                else
                begin
                    cmd.ex_read = 1'b1;
                    state_next  = S_EXSWAP;
                end
            end
            S_EXSWAP:
            begin
                // root goes to the tail slot, tail value sifts down from the root
                cmd.ex_swap  = 1'b1;
                extract_next = 1'b1;
                state_next   = S_SRD;
            end
            S_EMRD:
            begin
                if (stat.out_free)
                begin
                    cmd.em_read = 1'b1;
                    state_next  = S_EMLD;
                end
            end
            S_EMLD:
            begin
                cmd.em_load = 1'b1;
                state_next  = stat.em_last ? S_LOAD : S_EMRD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            extract_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            extract_reg <= extract_next;
        end
    end

endmodule
`default_nettype wire

### hdl/heap_sort_unit.sv
// Heap sort unit: loads a set of signed words, sorts it in place, streams it out ascending.
//
// Channels: items (value, last) in, results (sorted_value, end_of_set, overflow) out,
// both valid/ready; a transaction completes on a clock edge with valid and ready high.
// Loading takes one cycle per item. Items past the 64-entry store are dropped and every
// result of that set then carries overflow. The item flagged last closes the set.
// After the closing item the unit builds a max-heap and extracts it. Each sift level is a
// memory read of both children, then a compare and write; a build sift first takes its
// slot's value, an extraction step first moves the root to the tail slot and sifts the
// tail value down. Build and extraction share the single sift unit and its memory.
// Each result is then read from the store and loaded into the output register; the next
// read starts once that register is free or its result is being taken.
// The items channel is not ready from the closing item until the last result has been
// placed in the output register; that result may wait there while the next set loads.
// A stalled receiver holds emission; nothing is lost or repeated.
// Reset clears the set count, overflow flag, output valid and controller state; the
// store itself is not cleared, since only entries written for the current set are read.
`default_nettype none
module heap_sort_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    hs_in_if.sink        items,
    hs_out_if.source     results
);

    hs_pkg::cmd_t  cmd;
    hs_pkg::stat_t stat;

    hs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    hs_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule
`default_nettype wire

### sim/tb_heap_sort_unit.sv
// Testbench for heap_sort_unit: directed and random sets checked against a heapsort predictor.
`timescale 1ns / 100ps
module tb_heap_sort_unit;

    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 300;
    localparam int STALL_LIMIT = 8000;
    localparam int HOLD_CYCLES = 1600;
    localparam int HOLD_AFTER = 30;
    localparam int DRAIN_CYCLES = 32;
    localparam int NUM_ROWS = 20;

    localparam hs_pkg::word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam hs_pkg::word_t WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        hs_pkg::word_t value;
        logic          last;
        logic          typed;      // expected result given in the row (one-element sets only)
        hs_pkg::word_t exp_value;
    } stim_row_t;

    typedef struct {
        hs_pkg::word_t value;
        logic          end_of_set;
        logic          overflow;
    } sort_result_t;

    logic clk;
    logic rst_n;

    hs_in_if  items_ch();
    hs_out_if results_ch();

    heap_sort_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    // Typed rows are one-element sets; they come first, so the set being built is empty.
    stim_row_t directed_rows [0:NUM_ROWS-1] = '{
        '{32'sd0,        1'b1, 1'b1, 32'sd0},
        '{WORD_MAX,      1'b1, 1'b1, WORD_MAX},
        '{WORD_MIN,      1'b1, 1'b1, WORD_MIN},
        '{-32'sd1,       1'b1, 1'b1, -32'sd1},
        // extremes mixed with a duplicate
        '{32'sd5,        1'b0, 1'b0, 32'sd0},
        '{-32'sd3,       1'b0, 1'b0, 32'sd0},
        '{WORD_MAX,      1'b0, 1'b0, 32'sd0},
        '{WORD_MIN,      1'b0, 1'b0, 32'sd0},
        '{32'sd5,        1'b1, 1'b0, 32'sd0},
        // all equal
        '{32'sd9,        1'b0, 1'b0, 32'sd0},
        '{32'sd9,        1'b0, 1'b0, 32'sd0},
        '{32'sd9,        1'b1, 1'b0, 32'sd0},
        // pairs, already ordered and reversed
        '{32'sd1,        1'b0, 1'b0, 32'sd0},
        '{32'sd2,        1'b1, 1'b0, 32'sd0},
        '{32'sd2,        1'b0, 1'b0, 32'sd0},
        '{32'sd1,        1'b1, 1'b0, 32'sd0},
        // alternating bit patterns
        '{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
        '{32'shAAAA_AAAA, 1'b0, 1'b0, 32'sd0},
        '{32'sd0,         1'b0, 1'b0, 32'sd0},
        '{-32'sd1,        1'b1, 1'b0, 32'sd0}
    };

    hs_pkg::word_t set_buf [hs_pkg::DEPTH];
    int unsigned   set_len;
    logic          set_dropped;
    sort_result_t  expected_sorted [$];

    int unsigned  mismatch_count;
    int unsigned  results_seen;
    int unsigned  stall_cycles;
    int unsigned  burst_left;

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------- predictor ----------------
    function automatic void sift_down(int unsigned n, int unsigned root);
        int unsigned   cur;
        int unsigned   big;
        int unsigned   kid;
        hs_pkg::word_t tmp;
        logic          done;
        cur = root;
        done = 1'b0;
        while (!done)
        begin
            big = cur;
            kid = 2 * cur + 1;
            if (kid < n && set_buf[kid] > set_buf[big])
                big = kid;
            if (kid + 1 < n && set_buf[kid + 1] > set_buf[big])
                big = kid + 1;
            if (big == cur)
            begin
                done = 1'b1;
            end
            else
            begin
                tmp = set_buf[cur];
                set_buf[cur] = set_buf[big];
                set_buf[big] = tmp;
                cur = big;
            end
        end
    endfunction

    function automatic void predict_item(hs_pkg::word_t v, logic is_last);
        int unsigned   k;
        hs_pkg::word_t tmp;
        sort_result_t  r;
        if (set_len < hs_pkg::DEPTH)
        begin
            set_buf[set_len] = v;
            set_len++;
        end
        else
        begin
            set_dropped = 1'b1;
        end
        if (!is_last)
            return;
        for (k = set_len / 2; k > 0; k--)
            sift_down(set_len, k - 1);
        for (k = set_len; k > 1; k--)
        begin
            tmp = set_buf[0];
            set_buf[0] = set_buf[k - 1];
            set_buf[k - 1] = tmp;
            sift_down(k - 1, 0);
        end
        for (k = 0; k < set_len; k++)
        begin
            r.value = set_buf[k];
            r.end_of_set = (k + 1 == set_len);
            r.overflow = set_dropped;
            expected_sorted.push_back(r);
        end
        set_len = 0;
        set_dropped = 1'b0;
    endfunction

    // ---------------- sender ----------------
    task automatic pace();
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                items_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Offers one transaction and returns at the edge that accepts it.
    task automatic send_item(hs_pkg::word_t v, logic is_last);
        items_ch.valid <= 1'b1;
        items_ch.value <= v;
        items_ch.last  <= is_last;
        do
            @(posedge clk);
        while (!items_ch.ready);
    endtask

    function automatic hs_pkg::word_t pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return hs_pkg::word_t'($urandom);
        else if (sel < 9)
            return hs_pkg::word_t'(32'($urandom_range(0, 8)) - 32'd4);
        else
            case ($urandom_range(0, 3))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
    endfunction

    function automatic int unsigned pick_set_len(int unsigned set_idx);
        int unsigned r;
        // full store, one dropped closing item, three dropped items
        case (set_idx)
            0: return hs_pkg::DEPTH;
            1: return hs_pkg::DEPTH + 1;
            2: return hs_pkg::DEPTH + 3;
            default: ;
        endcase
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        else if (r < 90)
            return $urandom_range(9, 40);
        else
            return $urandom_range(hs_pkg::DEPTH - 2, hs_pkg::DEPTH + 6);
    endfunction

    initial
    begin
        int unsigned  items_sent;
        int unsigned  set_idx;
        int unsigned  len;
        int unsigned  i;
        sort_result_t r;

        rst_n = 1'b0;
        items_ch.valid = 1'b0;
        items_ch.value = '0;
        items_ch.last = 1'b0;
        set_len = 0;
        set_dropped = 1'b0;
        burst_left = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_ROWS; i++)
        begin
            pace();
            send_item(directed_rows[i].value, directed_rows[i].last);
            if (directed_rows[i].typed)
            begin
                r.value = directed_rows[i].exp_value;
                r.end_of_set = 1'b1;
                r.overflow = 1'b0;
                expected_sorted.push_back(r);
            end
            else
            begin
                predict_item(directed_rows[i].value, directed_rows[i].last);
            end
        end

        items_sent = 0;
        set_idx = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            len = pick_set_len(set_idx);
            for (i = 0; i < len; i++)
            begin
                hs_pkg::word_t v;
                v = pick_value();
                pace();
                send_item(v, i + 1 == len);
                predict_item(v, i + 1 == len);
            end
            items_sent += len;
            set_idx++;
        end
        items_ch.valid <= 1'b0;

        while (expected_sorted.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("** heap_sort_unit: PASSED **");
        else
            $display("** heap_sort_unit: FAILED **");
        $finish;
    end

    // ---------------- receiver ----------------
    initial
    begin
        int unsigned mode;
        int unsigned span;
        int unsigned hold_left;
        logic        hold_done;
        results_ch.ready = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: results_ch.ready <= 1'b1;
                    1: results_ch.ready <= $urandom_range(0, 1);
                    2: results_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: results_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
            // one long hold-off, longer than a full sort, while the sender keeps offering
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                @(posedge clk);
                results_ch.ready <= 1'b0;
                for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--)
                    @(posedge clk);
            end
        end
    end

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        sort_result_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            results_seen++;
            if (expected_sorted.size() == 0)
            begin
                $error("unexpected transaction: sorted_value %0d end_of_set %0b overflow %0b",
                       results_ch.sorted_value, results_ch.end_of_set, results_ch.overflow);
                mismatch_count++;
            end
            else
            begin
                want = expected_sorted.pop_front();
                if (results_ch.sorted_value !== want.value)
                begin
                    $error("sorted_value: expected %0d, actual %0d",
                           want.value, results_ch.sorted_value);
                    mismatch_count++;
                end
                if (results_ch.end_of_set !== want.end_of_set)
                begin
                    $error("end_of_set: expected %0b, actual %0b",
                           want.end_of_set, results_ch.end_of_set);
                    mismatch_count++;
                end
                if (results_ch.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, actual %0b",
                           want.overflow, results_ch.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("** heap_sort_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        mismatch_count = 0;
        results_seen = 0;
        stall_cycles = 0;
    end

endmodule
